FILE: rtl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants for the mode-0 SPI master shifter
// Beat layouts for both channels, the action and clock phase codes, and the
// byte geometry constants.
// ----------------------------------------------------------------------------
package spm_pkg;

  // Byte geometry.
  localparam logic [3:0] FullBits = 4'd8;
  localparam logic [3:0] MinBits  = 4'd1;

  // Kind of input beat.
  typedef enum logic {
    ActPush = 1'b0,
    ActTick = 1'b1
  } action_e;

  // Clock phase of the shifter.
  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhLow  = 2'd1,
    PhHigh = 2'd2,
    PhDone = 2'd3
  } phase_e;

  // Input beat.
  typedef struct packed {
    action_e    action;
    logic [7:0] tx_byte;
    logic [3:0] byte_bits;
    logic       end_of_transfer;
    logic       miso;
  } spm_in_t;

  // Result beat.
  typedef struct packed {
    logic       cs_n;
    logic       sclk;
    logic       mosi;
    logic       ready_res;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
  } spm_out_t;

  localparam int unsigned InWidth  = $bits(spm_in_t);
  localparam int unsigned OutWidth = $bits(spm_out_t);

endpackage

FILE: rtl/spm_pipe_reg.sv
// ----------------------------------------------------------------------------
// spm_pipe_reg: one-entry valid/ready pipeline register
// Holds one beat and passes it on; takes a new beat in the same cycle the
// held one leaves, so a full stream moves at one beat per cycle while downstream is ready.
// ----------------------------------------------------------------------------
module spm_pipe_reg import spm_pkg::*; #(
  parameter int unsigned Width = InWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  logic [Width-1:0] up_data_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output logic [Width-1:0] dn_data_o
);

  logic             valid_q, valid_d;
  logic [Width-1:0] data_q;

  // Room when empty or when the held beat leaves this cycle.
  assign up_ready_o = !valid_q || dn_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (up_valid_i && up_ready_o) begin
      valid_d = 1'b1;
    end else if (dn_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= up_data_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

FILE: rtl/spm_core.sv
// ----------------------------------------------------------------------------
// spm_core: SPI shifter state and per-beat update
// Holding register, transmit and receive shifters, bit counter and clock
// phase. One input beat is applied per strobe and the result is formed from
// the state that the beat leaves behind.
// ----------------------------------------------------------------------------
module spm_core import spm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     proc_i,
  input  spm_in_t  item_i,
  output spm_out_t result_o
);

  logic [7:0] out_shift_q, out_shift_d;
  logic [7:0] in_shift_q, in_shift_d;
  logic [3:0] bit_index_q, bit_index_d;
  logic [3:0] bits_target_q, bits_target_d;
  logic [7:0] hold_byte_q, hold_byte_d;
  logic       hold_full_q, hold_full_d;
  logic       hold_final_q, hold_final_d;
  logic       fin_q, fin_d;
  phase_e     phase_q, phase_d;

  logic [3:0] n_bits;
  logic [3:0] bit_inc;
  logic [3:0] shamt;
  logic [3:0] push_bits;
  logic [7:0] shifted_in;
  logic [7:0] rx_just;
  logic       push_ok;

  // Next state and result for the beat being applied.
  always_comb begin
    out_shift_d   = out_shift_q;
    in_shift_d    = in_shift_q;
    bit_index_d   = bit_index_q;
    bits_target_d = bits_target_q;
    hold_byte_d   = hold_byte_q;
    hold_full_d   = hold_full_q;
    hold_final_d  = hold_final_q;
    fin_d         = fin_q;
    phase_d       = phase_q;
    result_o      = '0;

    // Bit count of the byte in the shifter.
    n_bits = fin_q ? bits_target_q : FullBits;
    if (n_bits == 4'd0 || n_bits > FullBits) begin
      n_bits = FullBits;
    end
    bit_inc    = bit_index_q + 4'd1;
    shifted_in = {in_shift_q[6:0], item_i.miso};
    shamt      = FullBits - n_bits;
    rx_just    = 8'(shifted_in << shamt);

    // Clamp the requested bit count of a pushed final byte.
    push_bits = item_i.byte_bits;
    if (push_bits == 4'd0) begin
      push_bits = MinBits;
    end else if (push_bits inside {[4'd9:4'd15]}) begin
      push_bits = FullBits;
    end

    push_ok = !hold_full_q && !(fin_q && phase_q != PhIdle);

    if (proc_i) begin
      if (item_i.action == ActPush) begin
        if (push_ok) begin
          hold_byte_d   = item_i.tx_byte;
          hold_final_d  = item_i.end_of_transfer;
          bits_target_d = item_i.end_of_transfer ? push_bits : FullBits;
          hold_full_d   = 1'b1;
        end
      end else begin
        case (phase_q)
          PhIdle: begin
            if (hold_full_q) begin
              out_shift_d = hold_byte_q;
              in_shift_d  = '0;
              bit_index_d = '0;
              phase_d     = PhLow;
              fin_d       = hold_final_q;
              hold_full_d = 1'b0;
            end else begin
              phase_d = PhIdle;
              fin_d   = 1'b0;
            end
          end
          PhLow: begin
            // Rising edge: sample MISO and advance the transmit shifter.
            in_shift_d  = shifted_in;
            out_shift_d = {out_shift_q[6:0], 1'b0};
            bit_index_d = bit_inc;
            if (bit_inc >= n_bits) begin
              result_o.rx_valid = 1'b1;
              result_o.rx_byte  = rx_just;
              result_o.rx_last  = fin_q;
              phase_d           = PhDone;
            end else begin
              phase_d = PhHigh;
            end
          end
          PhHigh: begin
            phase_d = PhLow;
          end
          PhDone: begin
            // Close the transfer, chain the next byte, or hold SCLK high.
            if (fin_q) begin
              phase_d = PhIdle;
              fin_d   = 1'b0;
            end else if (hold_full_q) begin
              out_shift_d = hold_byte_q;
              in_shift_d  = '0;
              bit_index_d = '0;
              phase_d     = PhLow;
              fin_d       = hold_final_q;
              hold_full_d = 1'b0;
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end

    // Pin levels after the beat.
    result_o.cs_n      = (phase_d == PhIdle);
    result_o.sclk      = (phase_d == PhHigh) || (phase_d == PhDone);
    result_o.mosi      = out_shift_d[7];
    result_o.ready_res = !hold_full_d && !(fin_d && phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_shift_q   <= '0;
      in_shift_q    <= '0;
      bit_index_q   <= '0;
      bits_target_q <= FullBits;
      hold_full_q   <= 1'b0;
      hold_final_q  <= 1'b0;
      fin_q         <= 1'b0;
      phase_q       <= PhIdle;
    end else begin
      out_shift_q   <= out_shift_d;
      in_shift_q    <= in_shift_d;
      bit_index_q   <= bit_index_d;
      bits_target_q <= bits_target_d;
      hold_full_q   <= hold_full_d;
      hold_final_q  <= hold_final_d;
      fin_q         <= fin_d;
      phase_q       <= phase_d;
    end
  end

  // The holding byte is only read after a push has written it.
  always_ff @(posedge clk_i) begin
    hold_byte_q <= hold_byte_d;
  end

endmodule

FILE: rtl/spi_mode0_master_shifter.sv
// ----------------------------------------------------------------------------
// spi_mode0_master_shifter: mode-0 SPI master, MSB first
// Pushes fill a one-byte holding register; ticks advance SCLK by half a
// period each. One result beat per input beat carries the pin levels and
// any completed receive byte.
//
//   Channel | Direction | Handshake             | Beat
//   --------+-----------+-----------------------+----------
//   in      | input     | in_valid_i/in_ready_o | spm_in_t
//   out     | output    | out_valid_o/out_ready_i | spm_out_t
//
// One beat per clock cycle sustained while the output accepts beats; from the input
// handshake to the result beat a beat passes the input register, then the result register.
// The state update sits between those two registers and is a single pass.
// Reset clears control state and leaves SCLK low with chip select high.
// A stalled output holds its beat and back-pressures the input register.
// ----------------------------------------------------------------------------
module spi_mode0_master_shifter import spm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spm_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spm_out_t out_item_o
);

  logic                 stage_valid;
  logic                 res_ready;
  logic                 proc;
  logic [InWidth-1:0]   stage_bits;
  logic [OutWidth-1:0]  out_bits;
  spm_in_t              stage_item;
  spm_out_t             result;

  // Input register.
  spm_pipe_reg #(
    .Width(InWidth)
  ) u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .up_valid_i(in_valid_i),
    .up_ready_o(in_ready_o),
    .up_data_i (in_item_i),
    .dn_valid_o(stage_valid),
    .dn_ready_i(res_ready),
    .dn_data_o (stage_bits)
  );

  assign stage_item = spm_in_t'(stage_bits);
  assign proc       = stage_valid && res_ready;

  // Shifter state and update.
  spm_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .proc_i  (proc),
    .item_i  (stage_item),
    .result_o(result)
  );

  // Result register.
  spm_pipe_reg #(
    .Width(OutWidth)
  ) u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .up_valid_i(stage_valid),
    .up_ready_o(res_ready),
    .up_data_i (result),
    .dn_valid_o(out_valid_o),
    .dn_ready_i(out_ready_i),
    .dn_data_o (out_bits)
  );

  assign out_item_o = spm_out_t'(out_bits);

  // A byte completes only on a rising edge inside a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rx_valid |-> out_item_o.sclk && !out_item_o.cs_n)
    else $error("received byte reported outside a high clock phase");

  // The clock is low whenever chip select is released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.cs_n |-> !out_item_o.sclk)
    else $error("SCLK high with chip select released");

  // The final byte blocks pushes until the transfer has closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.rx_last |-> out_item_o.rx_valid && !out_item_o.ready_res)
    else $error("final byte reported with pushes still open");

  // A beat that enters the core reaches the result register next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_o)
    else $error("processed beat missing from result register");

endmodule
